// ----- src/pfla_pkg.sv -----
`default_nettype none

package pfla_pkg;

	localparam int ADDR_BITS      = 16;
	localparam int MIN_BLOCK_LOG2 = 3;
	localparam int NUM_CLASSES    = 14;

	localparam int SIZE_W   = 20;
	localparam int LIMIT_W  = 17;
	localparam int BYTES_W  = MIN_BLOCK_LOG2 + NUM_CLASSES;
	localparam int CLASS_W  = $clog2(NUM_CLASSES + 1);
	localparam int LINK_AW  = ADDR_BITS - MIN_BLOCK_LOG2;
	localparam int LINK_DW  = ADDR_BITS + 1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(65536);
	localparam logic [LIMIT_W-1:0] ADDR_TOP    = LIMIT_W'(1 << ADDR_BITS);

	localparam logic REG_HEAP_LIMIT = 1'b0;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_OOM      = 2'd1,
		STAT_BAD_SIZE = 2'd2,
		STAT_OUTSIDE  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASS,
		ST_DECIDE,
		ST_SEARCH,
		ST_POP_RD,
		ST_POP_LOAD,
		ST_SPLIT,
		ST_OUT
	} state_t;

	function automatic logic [BYTES_W-1:0] block_bytes(input logic [CLASS_W-1:0] c);
		block_bytes = BYTES_W'(1) << (MIN_BLOCK_LOG2 + int'(c));
	endfunction

	function automatic logic [LINK_AW-1:0] link_index(input logic [ADDR_BITS-1:0] a);
		link_index = a[ADDR_BITS-1:MIN_BLOCK_LOG2];
	endfunction

endpackage

`default_nettype wire

// ----- src/pfla_link_ram.sv -----
`default_nettype none

module pfla_link_ram #(
	parameter int ADDR_W = 13,
	parameter int DATA_W = 17
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [1 << ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- src/power_of_two_free_list_allocator.sv -----
`default_nettype none

// Power-of-two free-list allocator. Each transaction on the input stream is an allocate
// (tuser 0) or a free (tuser 1) with a byte size that is rounded up to a size class of
// 8 to 65536 bytes; one result transaction returns the block address and a status
// (ok, out of memory, bad size, free outside heap). Free blocks are kept on one linked
// list per class with the next links in an 8192-entry link memory; the heap grows from
// address 0 by a bump pointer up to the heap_limit register (APB, offset 0). One item
// is handled at a time by a sequencer around a single head/link update path. A free,
// a bump allocate or a bad size goes from the decide state straight to the result; a
// list pop reads the link memory's single registered read port and then loads the next
// link as the new head; an allocate that splits a block of class k down to class c
// searches the larger classes one by one, pops, and pushes the upper half back onto
// each class from k - 1 down to c; an out of memory allocate searches every larger
// class. The result stays valid until m_axis_tready is high. No clearing pass is
// needed after reset.

module power_of_two_free_list_allocator
	import pfla_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // request_size [19:0], block_address [39:20]
	input  wire logic        s_axis_tuser,  // command

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [23:0] m_axis_tdata,  // result_address [15:0], status [17:16], zero

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	state_t state_q, state_d;

	logic [LIMIT_W-1:0]   heap_limit_q;
	logic [LIMIT_W-1:0]   bump_q;
	logic [NUM_CLASSES-1:0] head_valid_q;
	logic [ADDR_BITS-1:0] head_addr_q [NUM_CLASSES];

	cmd_t                 cmd_q;
	logic [SIZE_W-1:0]    size_q;
	logic [SIZE_W-1:0]    addr_q;
	logic [CLASS_W-1:0]   cls_q;
	logic                 bad_q;
	logic [CLASS_W-1:0]   k_q;
	logic [ADDR_BITS-1:0] base_q;
	logic [ADDR_BITS-1:0] result_q;
	status_t              status_q;

	logic [CLASS_W-1:0]   size_cls;
	logic                 size_bad;
	logic [LIMIT_W-1:0]   eff_limit;
	logic                 outside;
	logic [LIMIT_W:0]     bump_sum;
	logic                 bump_fits;
	logic                 k_in_range;
	logic [CLASS_W-1:0]   k_dec;
	logic [ADDR_BITS-1:0] half_addr;

	logic                 link_we;
	logic [LINK_AW-1:0]   link_waddr;
	logic [LINK_DW-1:0]   link_wdata;
	logic [LINK_AW-1:0]   link_raddr;
	logic [LINK_DW-1:0]   link_rdata;

	logic                 head_we;
	logic [CLASS_W-1:0]   head_idx;
	logic                 head_wvalid;
	logic [ADDR_BITS-1:0] head_waddr;

	logic                 cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & pready & (paddr[2] == REG_HEAP_LIMIT);
	assign prdata = (paddr[2] == REG_HEAP_LIMIT) ? {{(32 - LIMIT_W){1'b0}}, heap_limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			heap_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		size_cls = '0;
		size_bad = 1'b1;
		for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
			if (size_q <= SIZE_W'(block_bytes(CLASS_W'(i)))) begin
				size_cls = CLASS_W'(i);
				size_bad = 1'b0;
			end
		end
		if (size_q == '0) begin
			size_bad = 1'b1;
		end
	end

	assign eff_limit  = (heap_limit_q > ADDR_TOP) ? ADDR_TOP : heap_limit_q;
	assign outside    = addr_q >= SIZE_W'(eff_limit);
	assign bump_sum   = {1'b0, bump_q} + (LIMIT_W + 1)'(block_bytes(cls_q));
	assign bump_fits  = bump_sum <= {1'b0, eff_limit};
	assign k_in_range = k_q < CLASS_W'(NUM_CLASSES);
	assign k_dec      = k_q - CLASS_W'(1);
	assign half_addr  = base_q + ADDR_BITS'(block_bytes(k_dec));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_CLASS;
				end
			end
			ST_CLASS: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (cmd_q == CMD_FREE || bad_q) begin
					state_d = ST_OUT;
				end else if (head_valid_q[cls_q]) begin
					state_d = ST_POP_RD;
				end else if (bump_fits) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (!k_in_range) begin
					state_d = ST_OUT;
				end else if (head_valid_q[k_q]) begin
					state_d = ST_POP_RD;
				end
			end
			ST_POP_RD: begin
				state_d = ST_POP_LOAD;
			end
			ST_POP_LOAD: begin
				state_d = (k_q == cls_q) ? ST_OUT : ST_SPLIT;
			end
			ST_SPLIT: begin
				if (k_dec == cls_q) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		link_we       = 1'b0;
		link_waddr    = '0;
		link_wdata    = '0;
		link_raddr    = link_index(head_addr_q[k_q]);
		head_we       = 1'b0;
		head_idx      = cls_q;
		head_wvalid   = 1'b1;
		head_waddr    = addr_q[ADDR_BITS-1:0];
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_DECIDE: begin
				if (cmd_q == CMD_FREE && !outside && !bad_q) begin
					link_we    = 1'b1;
					link_waddr = link_index(addr_q[ADDR_BITS-1:0]);
					link_wdata = {head_valid_q[cls_q], head_addr_q[cls_q]};
					head_we    = 1'b1;
				end
			end
			ST_POP_LOAD: begin
				head_we     = 1'b1;
				head_idx    = k_q;
				head_wvalid = link_rdata[ADDR_BITS];
				head_waddr  = link_rdata[ADDR_BITS-1:0];
			end
			ST_SPLIT: begin
				link_we    = 1'b1;
				link_waddr = link_index(half_addr);
				link_wdata = {head_valid_q[k_dec], head_addr_q[k_dec]};
				head_we    = 1'b1;
				head_idx   = k_dec;
				head_waddr = half_addr;
			end
			ST_OUT: begin
				m_axis_tvalid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tdata = {6'b0, status_q, result_q};

	pfla_link_ram #(
		.ADDR_W(LINK_AW),
		.DATA_W(LINK_DW)
	) u_link_ram (
		.clk  (clk),
		.we   (link_we),
		.waddr(link_waddr),
		.wdata(link_wdata),
		.raddr(link_raddr),
		.rdata(link_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_valid_q <= '0;
			bump_q       <= '0;
		end else begin
			state_q <= state_d;
			if (head_we) begin
				head_valid_q[head_idx] <= head_wvalid;
			end
			if (state_q == ST_DECIDE && cmd_q == CMD_ALLOC && !bad_q
			    && !head_valid_q[cls_q] && bump_fits) begin
				bump_q <= bump_sum[LIMIT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_addr_q[head_idx] <= head_waddr;
		end
		case (state_q)
			ST_IDLE: begin
				cmd_q  <= cmd_t'(s_axis_tuser);
				size_q <= s_axis_tdata[19:0];
				addr_q <= s_axis_tdata[39:20];
			end
			ST_CLASS: begin
				cls_q    <= size_cls;
				bad_q    <= size_bad;
				result_q <= '0;
				status_q <= STAT_OK;
			end
			ST_DECIDE: begin
				k_q <= head_valid_q[cls_q] ? cls_q : cls_q + CLASS_W'(1);
				if (cmd_q == CMD_FREE) begin
					if (outside) begin
						status_q <= STAT_OUTSIDE;
					end else if (bad_q) begin
						status_q <= STAT_BAD_SIZE;
					end
				end else if (bad_q) begin
					status_q <= STAT_BAD_SIZE;
				end else if (!head_valid_q[cls_q] && bump_fits) begin
					result_q <= bump_q[ADDR_BITS-1:0];
				end
			end
			ST_SEARCH: begin
				if (!k_in_range) begin
					status_q <= STAT_OOM;
				end else if (!head_valid_q[k_q]) begin
					k_q <= k_q + CLASS_W'(1);
				end
			end
			ST_POP_RD: begin
				base_q <= head_addr_q[k_q];
			end
			ST_POP_LOAD: begin
				result_q <= base_q;
			end
			ST_SPLIT: begin
				k_q <= k_dec;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
